// File: hdl/swk_pkg.sv
package swk_pkg;

  localparam int unsigned CfgCount = 6;
  localparam int unsigned NumWheels = 4;
  localparam int unsigned SqrtSteps = 18;
  localparam int unsigned CordicSteps = 16;

  localparam logic signed [27:0] TURN_Q8 = 28'sd27999729;
  localparam logic signed [27:0] HALF_Q8 = 28'sd13999864;
  localparam logic signed [27:0] QUARTER_Q8 = 28'sd6999808;

  localparam logic [16:0] RESET_OFFSET = 17'd0;
  localparam logic [15:0] RESET_LEVER = 16'd23170;
  localparam logic [15:0] RESET_GAIN = 16'd16141;

  typedef enum logic [2:0] {
    REG_OFFSET_FL = 3'd0,
    REG_OFFSET_FR = 3'd1,
    REG_OFFSET_BL = 3'd2,
    REG_OFFSET_BR = 3'd3,
    REG_LEVER     = 3'd4,
    REG_GAIN      = 3'd5
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEVER,
    S_SQUARE,
    S_LOAD,
    S_ITER,
    S_GAIN,
    S_TARGET,
    S_FINAL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       lever;
    logic       square;
    logic       load;
    logic       iter;
    logic       gain;
    logic       target;
    logic       finish;
    logic       publish;
    logic [1:0] wheel;
    logic [4:0] step;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } status_t;

  function automatic logic signed [25:0] atan_entry(input logic [3:0] i);
    logic signed [25:0] v;
    case (i)
      4'd0: v = 26'sd3499966;
      4'd1: v = 26'sd2066151;
      4'd2: v = 26'sd1091697;
      4'd3: v = 26'sd554163;
      4'd4: v = 26'sd278157;
      4'd5: v = 26'sd139214;
      4'd6: v = 26'sd69624;
      4'd7: v = 26'sd34814;
      4'd8: v = 26'sd17407;
      4'd9: v = 26'sd8704;
      4'd10: v = 26'sd4352;
      4'd11: v = 26'sd2176;
      4'd12: v = 26'sd1088;
      4'd13: v = 26'sd544;
      4'd14: v = 26'sd272;
      4'd15: v = 26'sd136;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/swk_if.sv
interface swk_req_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] yaw_rate;
  logic [16:0]        pos_wheel0;
  logic [16:0]        pos_wheel1;
  logic [16:0]        pos_wheel2;
  logic [16:0]        pos_wheel3;

  modport source (output valid, vel_x, vel_y, yaw_rate,
                  pos_wheel0, pos_wheel1, pos_wheel2, pos_wheel3, input ready);
  modport sink (input valid, vel_x, vel_y, yaw_rate,
                pos_wheel0, pos_wheel1, pos_wheel2, pos_wheel3, output ready);
endinterface

interface swk_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed_wheel0;
  logic signed [15:0] speed_wheel1;
  logic signed [15:0] speed_wheel2;
  logic signed [15:0] speed_wheel3;
  logic [16:0]        angle_wheel0;
  logic [16:0]        angle_wheel1;
  logic [16:0]        angle_wheel2;
  logic [16:0]        angle_wheel3;

  modport source (output valid, speed_wheel0, speed_wheel1, speed_wheel2, speed_wheel3,
                  angle_wheel0, angle_wheel1, angle_wheel2, angle_wheel3, input ready);
  modport sink (input valid, speed_wheel0, speed_wheel1, speed_wheel2, speed_wheel3,
                angle_wheel0, angle_wheel1, angle_wheel2, angle_wheel3, output ready);
endinterface

// File: hdl/swk_ctrl.sv
module swk_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  swk_pkg::status_t status,
  output swk_pkg::cmd_t    cmd
);
  import swk_pkg::*;

  state_t     state, state_next;
  logic [1:0] wheel, wheel_next;
  logic [4:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wheel <= 2'd0;
      step  <= 5'd0;
    end else begin
      state <= state_next;
      wheel <= wheel_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    wheel_next = wheel;
    step_next  = step;
    cmd        = '0;
    cmd.wheel  = wheel;
    cmd.step   = step;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LEVER;
        end
      end
      S_LEVER: begin
        cmd.lever  = 1'b1;
        wheel_next = 2'd0;
        state_next = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        step_next  = 5'd0;
        state_next = S_ITER;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        if (step == 5'(SqrtSteps - 1)) begin
          state_next = S_GAIN;
        end else begin
          step_next = step + 5'd1;
        end
      end
      S_GAIN: begin
        cmd.gain   = 1'b1;
        state_next = S_TARGET;
      end
      S_TARGET: begin
        cmd.target = 1'b1;
        state_next = S_FINAL;
      end
      S_FINAL: begin
        cmd.finish = 1'b1;
        if (wheel == 2'(NumWheels - 1)) begin
          state_next = S_DONE;
        end else begin
          wheel_next = wheel + 2'd1;
          state_next = S_SQUARE;
        end
      end
      S_DONE: begin
        if (!status.out_full) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hdl/swk_dp.sv
module swk_dp (
  input  logic                clk,
  input  logic                rst,
  input  swk_pkg::cmd_t       cmd,
  output swk_pkg::status_t    status,
  input  logic signed [15:0]  vel_x,
  input  logic signed [15:0]  vel_y,
  input  logic signed [15:0]  yaw_rate,
  input  logic [16:0]         pos_in [4],
  input  logic [16:0]         offset [4],
  input  logic [15:0]         lever,
  input  logic [15:0]         gain,
  input  logic                out_ready,
  output logic                out_valid,
  output logic signed [15:0]  wheel_speed [4],
  output logic [16:0]         wheel_angle [4]
);
  import swk_pkg::*;

  logic signed [15:0] vx, vy, wz;
  logic [16:0]        pos [4];
  logic               idle;
  logic signed [16:0] t;
  logic [34:0]        sqa, sqb;
  logic [35:0]        rem, root;
  logic signed [35:0] cx, cy;
  logic signed [25:0] cz;
  logic               zero_vec;
  logic [32:0]        prod;
  logic signed [27:0] tq;
  logic signed [16:0] held [4];
  logic signed [15:0] res_speed [4];
  logic [16:0]        res_angle [4];

  logic signed [17:0] vx_e, vy_e, t_e, a, b, ax, bx;
  logic signed [32:0] lever_prod;
  logic signed [35:0] a_sq, b_sq;
  logic [35:0]        bitv, trial;
  logic [5:0]         sh;
  logic [3:0]         ci;
  logic signed [35:0] dx, dy;
  logic signed [25:0] ang, zr;
  logic signed [16:0] h, hsel;
  logic signed [18:0] sum_c;
  logic signed [27:0] tq0, tq1;
  logic signed [27:0] diff, adiff, tq2, tq3, tq_r;
  logic               flip, neg;
  logic [20:0]        spd;
  logic signed [15:0] sv;

  assign vx_e = {{2{vx[15]}}, vx};
  assign vy_e = {{2{vy[15]}}, vy};
  assign t_e  = {t[16], t};
  assign a = cmd.wheel[1] ? vx_e - t_e : vx_e + t_e;
  assign b = (cmd.wheel == 2'd0 || cmd.wheel == 2'd3) ? vy_e - t_e : vy_e + t_e;
  assign ax = a[17] ? -a : a;
  assign bx = a[17] ? -b : b;
  assign lever_prod = wz * $signed({1'b0, lever});
  assign a_sq = a * a;
  assign b_sq = b * b;

  assign sh    = 6'd34 - {cmd.step, 1'b0};
  assign bitv  = 36'd1 << sh;
  assign trial = root + bitv;
  assign ci    = cmd.step[3:0];
  assign dx    = cy >>> ci;
  assign dy    = cx >>> ci;
  assign ang   = atan_entry(ci);

  assign zr   = (cz + 26'sd128) >>> 8;
  assign h    = zero_vec ? 17'sd0 : zr[16:0];
  assign hsel = idle ? held[cmd.wheel] : h;
  assign sum_c = $signed({2'b00, offset[cmd.wheel]}) + {{2{hsel[16]}}, hsel};
  assign tq0  = {{1{sum_c[18]}}, sum_c, 8'd0};
  assign tq1  = (tq0 >= TURN_Q8) ? tq0 - TURN_Q8 : tq0;
  assign tq_r = (tq1 < 0) ? tq1 + TURN_Q8 : tq1;

  assign diff  = $signed({3'b000, pos[cmd.wheel], 8'd0}) - tq;
  assign adiff = diff[27] ? -diff : diff;
  assign flip  = adiff > QUARTER_Q8;
  assign tq2   = tq - HALF_Q8;
  assign tq3   = flip ? ((tq2 < 0) ? tq2 + TURN_Q8 : tq2) : tq;
  assign spd   = prod[32:12];
  assign neg   = cmd.wheel[0] ^ flip;
  always_comb begin
    if (neg) begin
      sv = (spd >= 21'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, spd}));
    end else begin
      sv = (spd > 21'd32767) ? 16'sd32767 : $signed(spd[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      vx   <= vel_x;
      vy   <= vel_y;
      wz   <= yaw_rate;
      pos  <= pos_in;
      idle <= (vel_x == 16'sd0) && (vel_y == 16'sd0) && (yaw_rate == 16'sd0);
    end
    if (cmd.lever) begin
      t <= lever_prod[32:16];
    end
    if (cmd.square) begin
      sqa      <= a_sq[34:0];
      sqb      <= b_sq[34:0];
      zero_vec <= (a == 18'sd0) && (b == 18'sd0);
      cx       <= {{4{ax[17]}}, ax, 14'd0};
      cy       <= {{4{bx[17]}}, bx, 14'd0};
      cz       <= a[17] ? (b[17] ? -26'(HALF_Q8) : 26'(HALF_Q8)) : 26'sd0;
    end
    if (cmd.load) begin
      rem  <= {1'b0, sqa} + {1'b0, sqb};
      root <= 36'd0;
    end
    if (cmd.iter) begin
      if (rem >= trial) begin
        rem  <= rem - trial;
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      if (cmd.step < 5'(CordicSteps)) begin
        if (!cy[35]) begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + ang;
        end else begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - ang;
        end
      end
    end
    if (cmd.gain) begin
      prod <= root[16:0] * gain;
    end
    if (cmd.target) begin
      tq <= tq_r;
    end
    if (cmd.finish) begin
      res_speed[cmd.wheel] <= sv;
      res_angle[cmd.wheel] <= 17'((tq3 + 28'sd128) >>> 8);
    end
    if (cmd.publish) begin
      wheel_speed <= res_speed;
      wheel_angle <= res_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '{default: 17'sd0};
      out_valid <= 1'b0;
    end else begin
      if (cmd.target && !idle) begin
        held[cmd.wheel] <= h;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.out_full = out_valid && !out_ready;

endmodule

// File: hdl/swerve_wheel_kinematics_core.sv
// Four-wheel swerve inverse kinematics.
// req carries one chassis command (vel_x, vel_y, yaw_rate in Q8.8) and the
// four measured steer positions; rsp returns four signed wheel speeds and
// four steer targets in encoder counts. Both use valid/ready; a request is
// taken when valid and ready are high at a rising edge.
// From accept to rsp valid, a request passes the lever product, then for
// each wheel in turn the one shared 18-step square root, whose iterations
// also carry the 16-step CORDIC, and then the load of the output register.
// One request is in work at a time, so a new request is not accepted until
// the last one has been handed to the output register.
// rsp sits in an output register; a finished result waits there while the
// receiver stalls, and the next request is accepted meanwhile. The block
// then holds its own result until that register is free.
// Configuration: APB registers at 4*i; write only while idle.
// Reset (rst, synchronous): offsets 0, lever 23170, gain 16141, held
// headings 0, no result pending.
module swerve_wheel_kinematics_core (
  input  logic        clk,
  input  logic        rst,
  swk_req_if.sink     req,
  swk_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import swk_pkg::*;

  logic [16:0]        offset [4];
  logic [15:0]        lever, gain;
  logic [16:0]        pos_in [4];
  logic signed [15:0] wheel_speed [4];
  logic [16:0]        wheel_angle [4];
  cmd_t               cmd;
  status_t            status;
  reg_index_t         idx;

  assign pready = 1'b1;
  assign idx    = reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '{default: RESET_OFFSET};
      lever  <= RESET_LEVER;
      gain   <= RESET_GAIN;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_OFFSET_FL: offset[0] <= pwdata[16:0];
        REG_OFFSET_FR: offset[1] <= pwdata[16:0];
        REG_OFFSET_BL: offset[2] <= pwdata[16:0];
        REG_OFFSET_BR: offset[3] <= pwdata[16:0];
        REG_LEVER:     lever <= pwdata[15:0];
        REG_GAIN:      gain <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_OFFSET_FL: prdata = {15'd0, offset[0]};
      REG_OFFSET_FR: prdata = {15'd0, offset[1]};
      REG_OFFSET_BL: prdata = {15'd0, offset[2]};
      REG_OFFSET_BR: prdata = {15'd0, offset[3]};
      REG_LEVER:     prdata = {16'd0, lever};
      REG_GAIN:      prdata = {16'd0, gain};
      default:       prdata = 32'd0;
    endcase
  end

  assign pos_in[0] = req.pos_wheel0;
  assign pos_in[1] = req.pos_wheel1;
  assign pos_in[2] = req.pos_wheel2;
  assign pos_in[3] = req.pos_wheel3;

  swk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  swk_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .vel_x       (req.vel_x),
    .vel_y       (req.vel_y),
    .yaw_rate    (req.yaw_rate),
    .pos_in      (pos_in),
    .offset      (offset),
    .lever       (lever),
    .gain        (gain),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .wheel_speed (wheel_speed),
    .wheel_angle (wheel_angle)
  );

  assign rsp.speed_wheel0 = wheel_speed[0];
  assign rsp.speed_wheel1 = wheel_speed[1];
  assign rsp.speed_wheel2 = wheel_speed[2];
  assign rsp.speed_wheel3 = wheel_speed[3];
  assign rsp.angle_wheel0 = wheel_angle[0];
  assign rsp.angle_wheel1 = wheel_angle[1];
  assign rsp.angle_wheel2 = wheel_angle[2];
  assign rsp.angle_wheel3 = wheel_angle[3];

endmodule

// File: hdl/swk_checker.sv
module swk_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] speed0,
  input logic [16:0] angle0
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  a_no_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !rsp_valid |=> !rsp_valid)
    else $error("result appeared too early");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result pending after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(speed0) && $stable(angle0))
    else $error("stalled result changed");

endmodule

bind swerve_wheel_kinematics_core swk_checker u_swk_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .speed0    (rsp.speed_wheel0),
  .angle0    (rsp.angle_wheel0)
);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import swk_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  swk_req_if req_bus ();
  swk_rsp_if rsp_bus ();

  swerve_wheel_kinematics_core u_top (
    .clk(clk), .rst(rst), .req(req_bus.sink), .rsp(rsp_bus.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] wz;
    logic [3:0][16:0]   pos;
  } drive_cmd_t;

  typedef struct packed {
    logic [3:0][15:0] speed;
    logic [3:0][16:0] angle;
  } wheel_set_t;

  localparam int WatchdogLimit = 20000;
  localparam longint TurnQ8 = 27999729;
  localparam longint HalfQ8 = 13999864;
  localparam longint QuarterQ8 = 6999808;

  drive_cmd_t cmd_queue[$];
  wheel_set_t wheel_sets_due[$];

  logic [3:0][16:0] mdl_offset;
  logic [15:0]      mdl_lever;
  logic [15:0]      mdl_gain;
  longint           mdl_heading[4];

  int  fail_count;
  int  idle_cycles;
  bit  calm;
  bit  req_taken;
  int  drv_gap;
  int  mon_gap;

  longint atan_step[16] = '{3499966, 2066151, 1091697, 554163, 278157, 139214, 69624,
                            34814, 17407, 8704, 4352, 2176, 1088, 544, 272, 136};

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root_floor(longint n);
    longint r;
    longint b;
    r = 0;
    b = 64'd1 << 40;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint steer_heading(longint a, longint b);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = a;
    y = b;
    z = 0;
    if (a == 0 && b == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? HalfQ8 : -HalfQ8;
      x = -x;
      y = -y;
    end
    x = x * 16384;
    y = y * 16384;
    for (int i = 0; i < 16; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + atan_step[i];
      end else begin
        x = x - dx; y = y + dy; z = z - atan_step[i];
      end
    end
    return floor_shift(z + 128, 8);
  endfunction

  function automatic wheel_set_t solve_wheels(drive_cmd_t c);
    wheel_set_t r;
    longint vx;
    longint vy;
    longint t;
    longint a;
    longint b;
    longint mag;
    longint spd;
    longint tq;
    longint diff;
    longint sv;
    bit flip;
    bit neg;
    bit idle;
    vx = longint'(c.vx);
    vy = longint'(c.vy);
    t = floor_shift(longint'(c.wz) * longint'(mdl_lever), 16);
    idle = (c.vx == 0 && c.vy == 0 && c.wz == 0);
    for (int w = 0; w < 4; w++) begin
      a = (w < 2) ? vx + t : vx - t;
      b = (w == 0 || w == 3) ? vy - t : vy + t;
      mag = root_floor(a * a + b * b);
      spd = (mag * longint'(mdl_gain)) >> 12;
      if (!idle) mdl_heading[w] = steer_heading(a, b);
      tq = (longint'(mdl_offset[w]) + mdl_heading[w]) * 256;
      if (tq >= TurnQ8) tq = tq - TurnQ8;
      if (tq < 0) tq = tq + TurnQ8;
      diff = longint'(c.pos[w]) * 256 - tq;
      if (diff < 0) diff = -diff;
      flip = diff > QuarterQ8;
      if (flip) begin
        tq = tq - HalfQ8;
        if (tq < 0) tq = tq + TurnQ8;
      end
      neg = (w % 2 == 1) != flip;
      if (neg) sv = (spd >= 32768) ? -32768 : -spd;
      else sv = (spd > 32767) ? 32767 : spd;
      r.speed[w] = sv[15:0];
      r.angle[w] = 17'((tq + 128) >> 8);
    end
    return r;
  endfunction

  function automatic logic [16:0] any_pos();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 17'd0;
    if (k == 1) return 17'd109373;
    if (k == 2) return 17'($urandom());
    return 17'($urandom_range(0, 109373));
  endfunction

  function automatic logic signed [15:0] any_vel();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'sh7FFF;
    if (k == 1) return 16'sh8000;
    if (k == 2) return 16'sd0;
    if (k < 6) return $signed(16'($urandom_range(0, 1023)) - 16'd512);
    return 16'($urandom());
  endfunction

  function automatic drive_cmd_t any_cmd();
    drive_cmd_t c;
    c.vx = any_vel();
    c.vy = any_vel();
    c.wz = any_vel();
    if ($urandom_range(0, 19) == 0) begin
      c.vx = 16'sd0; c.vy = 16'sd0; c.wz = 16'sd0;
    end
    for (int w = 0; w < 4; w++) c.pos[w] = any_pos();
    return c;
  endfunction

  function automatic drive_cmd_t make_cmd(int vx, int vy, int wz, int p);
    drive_cmd_t c;
    c.vx = 16'(vx);
    c.vy = 16'(vy);
    c.wz = 16'(wz);
    for (int w = 0; w < 4; w++) c.pos[w] = 17'(p);
    return c;
  endfunction

  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = 5'(idx) << 2; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      REG_OFFSET_FL: mdl_offset[0] = val[16:0];
      REG_OFFSET_FR: mdl_offset[1] = val[16:0];
      REG_OFFSET_BL: mdl_offset[2] = val[16:0];
      REG_OFFSET_BR: mdl_offset[3] = val[16:0];
      REG_LEVER:     mdl_lever = val[15:0];
      REG_GAIN:      mdl_gain = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (cmd_queue.size() == 0 && !req_bus.valid && wheel_sets_due.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  task automatic run_burst(int n);
    for (int i = 0; i < n; i++) cmd_queue.push_back(any_cmd());
    drain();
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    req_taken <= req_bus.valid && req_bus.ready;
  end

  always @(negedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
      drv_gap <= 0;
    end else if (req_bus.valid && !req_taken) begin
    end else if (drv_gap > 0) begin
      req_bus.valid <= 1'b0;
      drv_gap <= drv_gap - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      req_bus.valid <= 1'b0;
      drv_gap <= $urandom_range(0, 6);
    end else if (cmd_queue.size() > 0) begin
      drive_cmd_t c;
      c = cmd_queue.pop_front();
      req_bus.valid <= 1'b1;
      req_bus.vel_x <= c.vx;
      req_bus.vel_y <= c.vy;
      req_bus.yaw_rate <= c.wz;
      req_bus.pos_wheel0 <= c.pos[0];
      req_bus.pos_wheel1 <= c.pos[1];
      req_bus.pos_wheel2 <= c.pos[2];
      req_bus.pos_wheel3 <= c.pos[3];
    end else begin
      req_bus.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      mon_gap <= 0;
    end else if (mon_gap > 0) begin
      rsp_bus.ready <= 1'b0;
      mon_gap <= mon_gap - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      rsp_bus.ready <= 1'b0;
      mon_gap <= $urandom_range(0, 6);
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (req_bus.valid && req_bus.ready) begin
        drive_cmd_t c;
        c.vx = req_bus.vel_x;
        c.vy = req_bus.vel_y;
        c.wz = req_bus.yaw_rate;
        c.pos[0] = req_bus.pos_wheel0;
        c.pos[1] = req_bus.pos_wheel1;
        c.pos[2] = req_bus.pos_wheel2;
        c.pos[3] = req_bus.pos_wheel3;
        wheel_sets_due.push_back(solve_wheels(c));
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        wheel_set_t e;
        wheel_set_t g;
        g.speed[0] = rsp_bus.speed_wheel0;
        g.speed[1] = rsp_bus.speed_wheel1;
        g.speed[2] = rsp_bus.speed_wheel2;
        g.speed[3] = rsp_bus.speed_wheel3;
        g.angle[0] = rsp_bus.angle_wheel0;
        g.angle[1] = rsp_bus.angle_wheel1;
        g.angle[2] = rsp_bus.angle_wheel2;
        g.angle[3] = rsp_bus.angle_wheel3;
        if (wheel_sets_due.size() == 0) begin
          $error("unexpected response");
          fail_count = fail_count + 1;
        end else begin
          e = wheel_sets_due.pop_front();
          for (int w = 0; w < 4; w++) begin
            if (g.speed[w] !== e.speed[w]) begin
              $error("speed_wheel%0d expected %0d actual %0d", w,
                     $signed(e.speed[w]), $signed(g.speed[w]));
              fail_count = fail_count + 1;
            end
            if (g.angle[w] !== e.angle[w]) begin
              $error("angle_wheel%0d expected %0d actual %0d", w, e.angle[w], g.angle[w]);
              fail_count = fail_count + 1;
            end
          end
        end
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    req_bus.valid = 1'b0;
    req_bus.vel_x = '0; req_bus.vel_y = '0; req_bus.yaw_rate = '0;
    req_bus.pos_wheel0 = '0; req_bus.pos_wheel1 = '0;
    req_bus.pos_wheel2 = '0; req_bus.pos_wheel3 = '0;
    rsp_bus.ready = 1'b0;
    fail_count = 0;
    idle_cycles = 0;
    calm = 1'b0;
    mdl_offset = '0;
    mdl_lever = RESET_LEVER;
    mdl_gain = RESET_GAIN;
    for (int w = 0; w < 4; w++) mdl_heading[w] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    cmd_queue.push_back(make_cmd(0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(256, 0, 0, 0));
    cmd_queue.push_back(make_cmd(0, 256, 0, 0));
    cmd_queue.push_back(make_cmd(-256, 0, 0, 54687));
    cmd_queue.push_back(make_cmd(-256, -1, 0, 0));
    cmd_queue.push_back(make_cmd(0, -256, 0, 109373));
    cmd_queue.push_back(make_cmd(0, 0, 0, 54687));
    cmd_queue.push_back(make_cmd(0, 0, 256, 27343));
    cmd_queue.push_back(make_cmd(0, 0, -32768, 0));
    cmd_queue.push_back(make_cmd(32767, 32767, 32767, 109373));
    cmd_queue.push_back(make_cmd(-32768, -32768, -32768, 0));
    cmd_queue.push_back(make_cmd(32767, -32768, 0, 131071));
    cmd_queue.push_back(make_cmd(1, 0, 0, 0));
    cmd_queue.push_back(make_cmd(0, 0, 0, 0));
    drain();

    write_reg(REG_LEVER, 32'd65535);
    write_reg(REG_GAIN, 32'd65535);
    write_reg(REG_OFFSET_FL, 32'd109373);
    write_reg(REG_OFFSET_FR, 32'd0);
    write_reg(REG_OFFSET_BL, 32'd54686);
    write_reg(REG_OFFSET_BR, 32'h1FFFF);
    cmd_queue.push_back(make_cmd(1, 1, 0, 0));
    cmd_queue.push_back(make_cmd(0, 0, 32767, 109373));
    cmd_queue.push_back(make_cmd(-32768, 0, 0, 0));
    run_burst(400);

    write_reg(REG_LEVER, 32'd0);
    write_reg(REG_GAIN, 32'd0);
    run_burst(150);

    for (int p = 0; p < 4; p++) begin
      write_reg(REG_OFFSET_FL, $urandom());
      write_reg(REG_OFFSET_FR, $urandom_range(0, 109373));
      write_reg(REG_OFFSET_BL, $urandom_range(0, 109373));
      write_reg(REG_OFFSET_BR, $urandom_range(0, 109373));
      write_reg(REG_LEVER, $urandom());
      write_reg(REG_GAIN, $urandom());
      run_burst(250);
    end

    write_reg(REG_OFFSET_FL, 32'd0);
    write_reg(REG_OFFSET_FR, 32'd0);
    write_reg(REG_OFFSET_BL, 32'd0);
    write_reg(REG_OFFSET_BR, 32'd0);
    write_reg(REG_LEVER, 32'(RESET_LEVER));
    write_reg(REG_GAIN, 32'(RESET_GAIN));
    calm = 1'b1;
    run_burst(400);

    if (fail_count == 0 && wheel_sets_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: swerve_wheel_kinematics_core.f
hdl/swk_pkg.sv
hdl/swk_if.sv
hdl/swk_ctrl.sv
hdl/swk_dp.sv
hdl/swerve_wheel_kinematics_core.sv
hdl/swk_checker.sv
tb/sv/tb.sv
